// ----- hdl/tbi_pkg.sv -----
// Shared types and constants for the barycentric triangle interpolator.
// Depends on nothing.
`default_nettype none
package tbi_pkg;
    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_DEGEN = 2'd2
    } status_t;
    localparam int TAG_BITS = 16;
endpackage
`default_nettype wire

// ----- hdl/tbi_geom.sv -----
// Geometry front end: edge deltas, products, area and numerators, then the inside test.
// Depends on tbi_pkg.
`default_nettype none
module tbi_geom
    import tbi_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VALUE_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] a_x,
    input  wire logic signed [COORD_BITS-1:0] a_y,
    input  wire logic signed [COORD_BITS-1:0] b_x,
    input  wire logic signed [COORD_BITS-1:0] b_y,
    input  wire logic signed [COORD_BITS-1:0] c_x,
    input  wire logic signed [COORD_BITS-1:0] c_y,
    input  wire logic signed [VALUE_BITS-1:0] f_a,
    input  wire logic signed [VALUE_BITS-1:0] f_b,
    input  wire logic signed [VALUE_BITS-1:0] f_c,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic        [TAG_BITS-1:0]   tag,
    output logic                              out_valid,
    output status_t                           out_status,
    output logic        [2*COORD_BITS+1:0]    out_nx,
    output logic        [2*COORD_BITS+1:0]    out_ne,
    output logic        [2*COORD_BITS+1:0]    out_d,
    output logic signed [VALUE_BITS-1:0]      out_fa,
    output logic signed [VALUE_BITS:0]        out_dfb,
    output logic signed [VALUE_BITS:0]        out_dfc,
    output logic        [TAG_BITS-1:0]        out_tag
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] dbx_reg, dby_reg, dcx_reg, dcy_reg, dqx_reg, dqy_reg;
    logic signed [VALUE_BITS-1:0] fa1_reg;
    logic signed [VALUE_BITS:0] dfb1_reg, dfc1_reg;
    logic [TAG_BITS-1:0] tag1_reg;
    logic v1_reg;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [VALUE_BITS-1:0] fa2_reg;
    logic signed [VALUE_BITS:0] dfb2_reg, dfc2_reg;
    logic [TAG_BITS-1:0] tag2_reg;
    logic v2_reg;

    logic signed [SW-1:0] d3_reg, nx3_reg, ne3_reg;
    logic signed [VALUE_BITS-1:0] fa3_reg;
    logic signed [VALUE_BITS:0] dfb3_reg, dfc3_reg;
    logic [TAG_BITS-1:0] tag3_reg;
    logic v3_reg;

    logic signed [SW-1:0] d_next, nx_next, ne_next;
    logic signed [SW:0] sum_next;
    status_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dbx_reg <= DW'(b_x) - DW'(a_x);
        dby_reg <= DW'(b_y) - DW'(a_y);
        dcx_reg <= DW'(c_x) - DW'(a_x);
        dcy_reg <= DW'(c_y) - DW'(a_y);
        dqx_reg <= DW'(query_x) - DW'(a_x);
        dqy_reg <= DW'(query_y) - DW'(a_y);
        fa1_reg <= f_a;
        dfb1_reg <= (VALUE_BITS+1)'(f_b) - (VALUE_BITS+1)'(f_a);
        dfc1_reg <= (VALUE_BITS+1)'(f_c) - (VALUE_BITS+1)'(f_a);
        tag1_reg <= tag;

        p0_reg <= PW'(dbx_reg) * PW'(dcy_reg);
        p1_reg <= PW'(dcx_reg) * PW'(dby_reg);
        p2_reg <= PW'(dcy_reg) * PW'(dqx_reg);
        p3_reg <= PW'(dcx_reg) * PW'(dqy_reg);
        p4_reg <= PW'(dbx_reg) * PW'(dqy_reg);
        p5_reg <= PW'(dby_reg) * PW'(dqx_reg);
        fa2_reg <= fa1_reg;
        dfb2_reg <= dfb1_reg;
        dfc2_reg <= dfc1_reg;
        tag2_reg <= tag1_reg;

        d3_reg <= SW'(p0_reg) - SW'(p1_reg);
        nx3_reg <= SW'(p2_reg) - SW'(p3_reg);
        ne3_reg <= SW'(p4_reg) - SW'(p5_reg);
        fa3_reg <= fa2_reg;
        dfb3_reg <= dfb2_reg;
        dfc3_reg <= dfc2_reg;
        tag3_reg <= tag2_reg;
    end

    always_comb
    begin
        d_next = d3_reg;
        nx_next = nx3_reg;
        ne_next = ne3_reg;
        if (d3_reg < 0)
        begin
            d_next = -d3_reg;
            nx_next = -nx3_reg;
            ne_next = -ne3_reg;
        end
        sum_next = (SW+1)'(nx_next) + (SW+1)'(ne_next);
        if (d3_reg == '0)
            st_next = ST_DEGEN;
        else if (nx_next >= 0 && ne_next >= 0 && sum_next <= (SW+1)'(d_next))
            st_next = ST_INSIDE;
        else
            st_next = ST_OUTSIDE;
    end

    always_ff @(posedge clk)
    begin
        out_status <= st_next;
        out_nx <= nx_next[2*COORD_BITS+1:0];
        out_ne <= ne_next[2*COORD_BITS+1:0];
        out_d <= d_next[2*COORD_BITS+1:0];
        out_fa <= fa3_reg;
        out_dfb <= dfb3_reg;
        out_dfc <= dfc3_reg;
        out_tag <= tag3_reg;
    end
endmodule
`default_nettype wire

// ----- hdl/tbi_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for two weights sharing a divisor.
// Depends on tbi_pkg.
`default_nettype none
module tbi_div
    import tbi_pkg::*;
#(
    parameter int NUM_BITS = 34,
    parameter int FRAC_BITS = 16,
    parameter int VALUE_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire status_t                     in_status,
    input  wire logic [NUM_BITS-1:0]         in_nx,
    input  wire logic [NUM_BITS-1:0]         in_ne,
    input  wire logic [NUM_BITS-1:0]         in_d,
    input  wire logic signed [VALUE_BITS-1:0] in_fa,
    input  wire logic signed [VALUE_BITS:0]  in_dfb,
    input  wire logic signed [VALUE_BITS:0]  in_dfc,
    input  wire logic [TAG_BITS-1:0]         in_tag,
    output logic                             out_valid,
    output status_t                          out_status,
    output logic [FRAC_BITS:0]               out_xq,
    output logic [FRAC_BITS:0]               out_eq,
    output logic signed [VALUE_BITS-1:0]     out_fa,
    output logic signed [VALUE_BITS:0]       out_dfb,
    output logic signed [VALUE_BITS:0]       out_dfc,
    output logic [TAG_BITS-1:0]              out_tag
);
    localparam int NS = FRAC_BITS + 1;
    localparam int RW = NUM_BITS + 1;

    logic             v_reg   [NS];
    status_t          st_reg  [NS];
    logic [RW-1:0]    rx_reg  [NS];
    logic [RW-1:0]    re_reg  [NS];
    logic [NUM_BITS-1:0] d_reg [NS];
    logic [FRAC_BITS:0] qx_reg [NS];
    logic [FRAC_BITS:0] qe_reg [NS];
    logic signed [VALUE_BITS-1:0] fa_reg [NS];
    logic signed [VALUE_BITS:0] dfb_reg [NS];
    logic signed [VALUE_BITS:0] dfc_reg [NS];
    logic [TAG_BITS-1:0] tag_reg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [RW-1:0] ax, ae;
        st_reg[0] <= in_status;
        d_reg[0] <= in_d;
        fa_reg[0] <= in_fa;
        dfb_reg[0] <= in_dfb;
        dfc_reg[0] <= in_dfc;
        tag_reg[0] <= in_tag;
        if (in_nx >= in_d)
        begin
            rx_reg[0] <= RW'(in_nx - in_d);
            qx_reg[0] <= (FRAC_BITS+1)'(1);
        end
        else
        begin
            rx_reg[0] <= RW'(in_nx);
            qx_reg[0] <= '0;
        end
        if (in_ne >= in_d)
        begin
            re_reg[0] <= RW'(in_ne - in_d);
            qe_reg[0] <= (FRAC_BITS+1)'(1);
        end
        else
        begin
            re_reg[0] <= RW'(in_ne);
            qe_reg[0] <= '0;
        end
        for (int i = 1; i < NS; i++)
        begin
            ax = {rx_reg[i-1][RW-2:0], 1'b0};
            ae = {re_reg[i-1][RW-2:0], 1'b0};
            st_reg[i] <= st_reg[i-1];
            d_reg[i] <= d_reg[i-1];
            fa_reg[i] <= fa_reg[i-1];
            dfb_reg[i] <= dfb_reg[i-1];
            dfc_reg[i] <= dfc_reg[i-1];
            tag_reg[i] <= tag_reg[i-1];
            if (ax >= RW'(d_reg[i-1]))
            begin
                rx_reg[i] <= ax - RW'(d_reg[i-1]);
                qx_reg[i] <= {qx_reg[i-1][FRAC_BITS-1:0], 1'b1};
            end
            else
            begin
                rx_reg[i] <= ax;
                qx_reg[i] <= {qx_reg[i-1][FRAC_BITS-1:0], 1'b0};
            end
            if (ae >= RW'(d_reg[i-1]))
            begin
                re_reg[i] <= ae - RW'(d_reg[i-1]);
                qe_reg[i] <= {qe_reg[i-1][FRAC_BITS-1:0], 1'b1};
            end
            else
            begin
                re_reg[i] <= ae;
                qe_reg[i] <= {qe_reg[i-1][FRAC_BITS-1:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_status = st_reg[NS-1];
    assign out_xq = qx_reg[NS-1];
    assign out_eq = qe_reg[NS-1];
    assign out_fa = fa_reg[NS-1];
    assign out_dfb = dfb_reg[NS-1];
    assign out_dfc = dfc_reg[NS-1];
    assign out_tag = tag_reg[NS-1];
endmodule
`default_nettype wire

// ----- hdl/tbi_blend.sv -----
// Weighted blend of vertex values: two products, then sum and floor shift, then result register.
// Depends on tbi_pkg.
`default_nettype none
module tbi_blend
    import tbi_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int VALUE_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire status_t                      in_status,
    input  wire logic [FRAC_BITS:0]           in_xq,
    input  wire logic [FRAC_BITS:0]           in_eq,
    input  wire logic signed [VALUE_BITS-1:0] in_fa,
    input  wire logic signed [VALUE_BITS:0]   in_dfb,
    input  wire logic signed [VALUE_BITS:0]   in_dfc,
    input  wire logic [TAG_BITS-1:0]          in_tag,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [VALUE_BITS-1:0]      value_out,
    output logic [FRAC_BITS:0]                xsi_out,
    output logic [FRAC_BITS:0]                eta_out,
    output logic [TAG_BITS-1:0]               tag_out
);
    localparam int MW = VALUE_BITS + FRAC_BITS + 3;

    logic v1_reg;
    status_t st1_reg;
    logic signed [MW-1:0] px_reg, pe_reg;
    logic signed [VALUE_BITS-1:0] fa1_reg;
    logic [FRAC_BITS:0] xq1_reg, eq1_reg;
    logic [TAG_BITS-1:0] tag1_reg;
    logic signed [MW:0] s_next;
    logic inside_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            done <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= MW'($signed({1'b0, in_xq})) * MW'(in_dfb);
        pe_reg <= MW'($signed({1'b0, in_eq})) * MW'(in_dfc);
        st1_reg <= in_status;
        fa1_reg <= in_fa;
        xq1_reg <= in_xq;
        eq1_reg <= in_eq;
        tag1_reg <= in_tag;
    end

    always_comb
    begin
        s_next = ((MW+1)'(fa1_reg) <<< FRAC_BITS) + (MW+1)'(px_reg) + (MW+1)'(pe_reg);
        inside_next = (st1_reg == ST_INSIDE);
    end

    always_ff @(posedge clk)
    begin
        status <= st1_reg;
        tag_out <= tag1_reg;
        value_out <= inside_next ? VALUE_BITS'(s_next >>> FRAC_BITS) : '0;
        xsi_out <= inside_next ? xq1_reg : '0;
        eta_out <= inside_next ? eq1_reg : '0;
    end
endmodule
`default_nettype wire

// ----- hdl/triangle_barycentric_interpolator_top.sv -----
// Top level of the barycentric triangle interpolator.
// Depends on tbi_pkg, tbi_geom, tbi_div and tbi_blend.
//
// Usage: drive the triangle, vertex values, query point and tag with start high;
// busy is always low, so a request is taken on every cycle that start is high.
// Each request yields one result marked by done for a single cycle, in order.
// The pipeline has four geometry stages (deltas, products, area and
// numerators, containment), FRAC_BITS+1 divider stages, one quotient bit
// per stage, and two blend stages.
// Throughput is one request per cycle; the pipeline has no feedback path.
// Status 0 is inside, 1 outside, 2 zero area; weights and value are zero
// unless inside. Reset clears every valid bit, so no result appears until a
// request enters after reset. The receiver cannot stall: results must be
// taken in the cycle done is high.
`default_nettype none
module triangle_barycentric_interpolator_top
    import tbi_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VALUE_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] a_x,
    input  wire logic signed [COORD_BITS-1:0] a_y,
    input  wire logic signed [COORD_BITS-1:0] b_x,
    input  wire logic signed [COORD_BITS-1:0] b_y,
    input  wire logic signed [COORD_BITS-1:0] c_x,
    input  wire logic signed [COORD_BITS-1:0] c_y,
    input  wire logic signed [VALUE_BITS-1:0] f_a,
    input  wire logic signed [VALUE_BITS-1:0] f_b,
    input  wire logic signed [VALUE_BITS-1:0] f_c,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic        [TAG_BITS-1:0]   tag,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [VALUE_BITS-1:0]      value_out,
    output logic [FRAC_BITS:0]                xsi_out,
    output logic [FRAC_BITS:0]                eta_out,
    output logic [TAG_BITS-1:0]               tag_out
);
    localparam int NB = 2 * COORD_BITS + 2;

    logic g_valid, q_valid;
    status_t g_status, q_status;
    logic [NB-1:0] g_nx, g_ne, g_d;
    logic signed [VALUE_BITS-1:0] g_fa, q_fa;
    logic signed [VALUE_BITS:0] g_dfb, g_dfc, q_dfb, q_dfc;
    logic [TAG_BITS-1:0] g_tag, q_tag;
    logic [FRAC_BITS:0] q_xq, q_eq;

    assign busy = 1'b0;

    tbi_geom #(.COORD_BITS(COORD_BITS), .VALUE_BITS(VALUE_BITS)) u_geom (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .c_x(c_x), .c_y(c_y),
        .f_a(f_a), .f_b(f_b), .f_c(f_c), .query_x(query_x), .query_y(query_y),
        .tag(tag), .out_valid(g_valid), .out_status(g_status),
        .out_nx(g_nx), .out_ne(g_ne), .out_d(g_d), .out_fa(g_fa),
        .out_dfb(g_dfb), .out_dfc(g_dfc), .out_tag(g_tag)
    );

    tbi_div #(.NUM_BITS(NB), .FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(g_valid), .in_status(g_status),
        .in_nx(g_nx), .in_ne(g_ne), .in_d(g_d), .in_fa(g_fa),
        .in_dfb(g_dfb), .in_dfc(g_dfc), .in_tag(g_tag),
        .out_valid(q_valid), .out_status(q_status), .out_xq(q_xq), .out_eq(q_eq),
        .out_fa(q_fa), .out_dfb(q_dfb), .out_dfc(q_dfc), .out_tag(q_tag)
    );

    tbi_blend #(.FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS)) u_blend (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_status(q_status),
        .in_xq(q_xq), .in_eq(q_eq), .in_fa(q_fa), .in_dfb(q_dfb), .in_dfc(q_dfc),
        .in_tag(q_tag), .done(done), .status(status), .value_out(value_out),
        .xsi_out(xsi_out), .eta_out(eta_out), .tag_out(tag_out)
    );
endmodule
`default_nettype wire

// ----- hdl/tbi_checker.sv -----
// Port-level checks of the interpolator results, bound to the top level.
// Depends on tbi_pkg and triangle_barycentric_interpolator_top.
`default_nettype none
module tbi_checker
    import tbi_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    busy,
    input wire logic                    done,
    input wire logic [1:0]              status,
    input wire logic [VALUE_BITS-1:0]   value_out,
    input wire logic [FRAC_BITS:0]      xsi_out,
    input wire logic [FRAC_BITS:0]      eta_out
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_INSIDE || status == ST_OUTSIDE || status == ST_DEGEN))
        else $error("bad status code");
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_INSIDE) |-> (value_out == '0 && xsi_out == '0 && eta_out == '0))
        else $error("nonzero result outside");
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, xsi_out} + {1'b0, eta_out} <= ((FRAC_BITS+2)'(1) << FRAC_BITS)))
        else $error("weights exceed one");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

bind triangle_barycentric_interpolator_top tbi_checker #(
    .VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)
) u_tbi_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done), .status(status),
    .value_out(value_out), .xsi_out(xsi_out), .eta_out(eta_out)
);
`default_nettype wire

// ----- bench/tb_triangle_barycentric_interpolator_top.sv -----
// Self-checking bench for the barycentric triangle interpolator top level.
// Drives triangle requests (directed table, then random) and checks each result
// against the table or a predictor. Depends on tbi_pkg and the interpolator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_barycentric_interpolator_top;
    import tbi_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = FB + 7;
    localparam int WATCHDOG = 2000;
    localparam int N_RANDOM = 1130;

    typedef struct packed {
        logic signed [15:0] ax, ay, bx, by, cx, cy, fa, fb, fc, qx, qy;
        logic [15:0] tg;
    } tri_req_t;

    typedef struct packed {
        status_t st;
        logic signed [15:0] val;
        logic [FB:0] xsi, eta;
        logic [15:0] tg;
    } interp_t;

    typedef struct {
        tri_req_t req;
        bit typed;
        interp_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tri_req_t drv = '0;
    logic done;
    logic [1:0] status;
    logic signed [15:0] value_out;
    logic [FB:0] xsi_out, eta_out;
    logic [15:0] tag_out;

    interp_t pending[$];
    row_t rows[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    triangle_barycentric_interpolator_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(drv.ax), .a_y(drv.ay), .b_x(drv.bx), .b_y(drv.by),
        .c_x(drv.cx), .c_y(drv.cy), .f_a(drv.fa), .f_b(drv.fb), .f_c(drv.fc),
        .query_x(drv.qx), .query_y(drv.qy), .tag(drv.tg),
        .done(done), .status(status), .value_out(value_out),
        .xsi_out(xsi_out), .eta_out(eta_out), .tag_out(tag_out)
    );

    function automatic logic [FB:0] weight_q(longint num, longint den);
        longint q;
        q = (num <<< FB) / den;
        return q[FB:0];
    endfunction

    function automatic interp_t interpolate(tri_req_t r);
        interp_t o;
        longint dbx, dby, dcx, dcy, dqx, dqy, d, nx, ne, s;
        o = '0;
        o.tg = r.tg;
        dbx = longint'(r.bx) - r.ax;
        dby = longint'(r.by) - r.ay;
        dcx = longint'(r.cx) - r.ax;
        dcy = longint'(r.cy) - r.ay;
        dqx = longint'(r.qx) - r.ax;
        dqy = longint'(r.qy) - r.ay;
        d = dbx * dcy - dcx * dby;
        nx = dcy * dqx - dcx * dqy;
        ne = dbx * dqy - dby * dqx;
        if (d == 0)
        begin
            o.st = ST_DEGEN;
            return o;
        end
        if (d < 0)
        begin
            d = -d;
            nx = -nx;
            ne = -ne;
        end
        if (nx >= 0 && ne >= 0 && nx + ne <= d)
        begin
            o.st = ST_INSIDE;
            o.xsi = weight_q(nx, d);
            o.eta = weight_q(ne, d);
            s = (longint'(r.fa) <<< FB) + longint'(o.xsi) * (longint'(r.fb) - r.fa)
                + longint'(o.eta) * (longint'(r.fc) - r.fa);
            s = s >>> FB;
            o.val = s[15:0];
        end
        else
            o.st = ST_OUTSIDE;
        return o;
    endfunction

    function automatic tri_req_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                    int fa, int fb, int fc, int qx, int qy, int tg);
        tri_req_t r;
        r = {16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy),
             16'(fa), 16'(fb), 16'(fc), 16'(qx), 16'(qy), 16'(tg)};
        return r;
    endfunction

    function automatic interp_t mkres(status_t st, int val, int xsi, int eta, int tg);
        interp_t o;
        o.st = st;
        o.val = 16'(val);
        o.xsi = (FB + 1)'(xsi);
        o.eta = (FB + 1)'(eta);
        o.tg = 16'(tg);
        return o;
    endfunction

    task automatic add_row(tri_req_t r, bit typed, interp_t res);
        row_t w;
        w.req = r;
        w.typed = typed;
        w.res = res;
        rows.push_back(w);
    endtask

    function automatic tri_req_t random_request();
        tri_req_t r;
        int span;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 7)
        begin
            span = 1 << $urandom_range(2, 15);
            r.bx = r.ax + 16'(($urandom % span) - span / 2);
            r.by = r.ay + 16'(($urandom % span) - span / 2);
            r.cx = r.ax + 16'(($urandom % span) - span / 2);
            r.cy = r.ay + 16'(($urandom % span) - span / 2);
            case ($urandom_range(0, 3))
                0: begin r.qx = r.ax; r.qy = r.ay; end
                1: begin r.qx = r.ax + (r.bx - r.ax) / 2; r.qy = r.ay + (r.by - r.ay) / 2; end
                default:
                begin
                    r.qx = 16'((int'(r.ax) + r.bx + r.cx) / 3
                               + int'($urandom_range(0, 6)) - 3);
                    r.qy = 16'((int'(r.ay) + r.by + r.cy) / 3
                               + int'($urandom_range(0, 6)) - 3);
                end
            endcase
        end
        if ($urandom_range(0, 19) == 0)
        begin
            r.cx = r.bx;
            r.cy = r.by;
        end
        return r;
    endfunction

    // drive requests
    initial
    begin
        tri_req_t r;
        int gap;
        add_row(mk(0, 0, 0, 0, 0, 0, 5, 6, 7, 0, 0, 16'h0001), 1,
                mkres(ST_DEGEN, 0, 0, 0, 16'h0001));
        add_row(mk(0, 0, 4, 0, 0, 4, 100, 200, 300, 0, 0, 16'hFFFF), 1,
                mkres(ST_INSIDE, 100, 0, 0, 16'hFFFF));
        add_row(mk(0, 0, 4, 0, 0, 4, 100, 200, 300, 4, 0, 16'h0002), 1,
                mkres(ST_INSIDE, 200, 65536, 0, 16'h0002));
        add_row(mk(0, 0, 4, 0, 0, 4, 100, 200, 300, 0, 4, 16'h0003), 1,
                mkres(ST_INSIDE, 300, 0, 65536, 16'h0003));
        add_row(mk(0, 0, 0, 4, 4, 0, 1, 2, 3, 0, 4, 16'h0004), 1,
                mkres(ST_INSIDE, 2, 65536, 0, 16'h0004));
        add_row(mk(0, 0, 4, 0, 0, 4, 1, 2, 3, 5, 5, 16'h0005), 1,
                mkres(ST_OUTSIDE, 0, 0, 0, 16'h0005));
        add_row(mk(0, 0, 4, 0, 0, 4, 1, 2, 3, -1, 0, 16'h0006), 1,
                mkres(ST_OUTSIDE, 0, 0, 0, 16'h0006));
        add_row(mk(0, 0, 4, 0, 0, 4, 1, 2, 3, 2, 2, 16'h0007), 0, '0);
        add_row(mk(0, 0, 3, 0, 0, 3, -32768, 32767, 0, 1, 1, 16'h0008), 0, '0);
        add_row(mk(0, 0, 6, 0, 6, 6, 32767, -32768, -32768, 5, 1, 16'h0009), 0, '0);
        add_row(mk(-32768, -32768, 32767, -32768, -32768, 32767,
                   -32768, 32767, 32767, 0, 0, 16'h8000), 0, '0);
        add_row(mk(32767, 32767, -32768, 32767, 32767, -32768,
                   32767, -32768, 0, 32767, 32767, 16'h7FFF), 1,
                mkres(ST_INSIDE, 32767, 0, 0, 16'h7FFF));
        add_row(mk(-32768, -32768, 32767, 32767, 0, 0, 1, 2, 3, 0, 0, 16'h00AA), 1,
                mkres(ST_DEGEN, 0, 0, 0, 16'h00AA));
        add_row(mk(-32768, -32768, 32767, -32768, -32768, 32767,
                   1, 2, 3, 32767, 32767, 16'h5555), 1,
                mkres(ST_OUTSIDE, 0, 0, 0, 16'h5555));
        add_row(mk(0, 0, 7, 1, 2, 9, -5, 9, -13, 3, 4, 16'h1234), 0, '0);
        for (int i = 0; i < N_RANDOM; i++)
            add_row(random_request(), 0, '0);

        drv = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < rows.size(); i++)
        begin
            r = rows[i].req;
            if (i < rows.size() - 150 && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 4);
                start <= 1'b0;
                drv <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                repeat (gap) @(negedge clk);
            end
            start <= 1'b1;
            drv <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending.push_back(rows[i].typed ? rows[i].res : interpolate(r));
            @(negedge clk);
        end
        start <= 1'b0;
        stim_done = 1'b1;
    end

    // check results
    always @(posedge clk)
    begin
        interp_t exp_r;
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result tag %h", $time, tag_out);
                errors++;
            end
            else
            begin
                exp_r = pending.pop_front();
                if (status !== exp_r.st || value_out !== exp_r.val
                    || xsi_out !== exp_r.xsi || eta_out !== exp_r.eta
                    || tag_out !== exp_r.tg)
                begin
                    $display("%0t: expected st=%0d val=%0d xsi=%0d eta=%0d tag=%h",
                             $time, exp_r.st, exp_r.val, exp_r.xsi, exp_r.eta, exp_r.tg);
                    $display("%0t: actual   st=%0d val=%0d xsi=%0d eta=%0d tag=%h",
                             $time, status, value_out, xsi_out, eta_out, tag_out);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no request accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
